// ----- sv/grc_pkg.sv -----
// Shared constants and types for the grid ray caster.
package grc_pkg;
  localparam int unsigned MAP_SIDE  = 64;
  localparam int unsigned CODE_BITS = 8;
  localparam int unsigned FRAC_BITS = 10;
  localparam int unsigned MAX_DEPTH = 100;

  localparam int unsigned CELL_BITS  = $clog2(MAP_SIDE);
  localparam int unsigned ADDR_BITS  = 2 * CELL_BITS;
  localparam int unsigned CELL_COUNT = MAP_SIDE * MAP_SIDE;
  localparam int unsigned ENTRY_BITS = CODE_BITS + 1;

  localparam int unsigned DIST_BITS = 17;
  localparam int unsigned DIST_MAX  = (1 << DIST_BITS) - 1;
  localparam int unsigned LIM_RAW   = MAX_DEPTH << FRAC_BITS;
  localparam int unsigned LIMIT     = (LIM_RAW > DIST_MAX) ? DIST_MAX : LIM_RAW;

  // Reciprocal numerator is 2^(14+FRAC_BITS); one quotient bit per cycle.
  localparam int unsigned QUO_BITS = 15 + FRAC_BITS;
  localparam int unsigned CNT_BITS = $clog2(QUO_BITS);

  localparam int unsigned OP_BITS   = 18;
  localparam int unsigned PROD_BITS = 2 * OP_BITS;
  localparam int unsigned POS_BITS  = 36;

  typedef logic [DIST_BITS-1:0] dist_t;
  typedef logic signed [OP_BITS-1:0] op_t;
  typedef logic signed [PROD_BITS-1:0] prod_t;
endpackage

// ----- sv/grc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module grc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ----- sv/grc_div.sv -----
// Restoring divider that forms a saturated 2^(14+FRAC_BITS) / divisor, one bit a cycle.
module grc_div (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [15:0]   divisor_i,
  output logic          done_o,
  output grc_pkg::dist_t quot_o
);
  import grc_pkg::*;

  logic                run_q, run_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic [15:0]         rem_q, rem_d;
  logic [QUO_BITS-1:0] quo_q, quo_d;
  logic [15:0]         div_q, div_d;
  logic                done_q, done_d;
  logic [16:0]         trial;
  logic                fits;

  // Only the leading dividend bit is set.
  assign trial = {rem_q, (cnt_q == '0)};
  assign fits  = trial >= {1'b0, div_q};

  always_comb begin
    run_d  = run_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    done_d = 1'b0;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      rem_d = '0;
      quo_d = '0;
      div_d = divisor_i;
    end else if (run_q) begin
      rem_d = fits ? 16'(trial - {1'b0, div_q}) : trial[15:0];
      quo_d = {quo_q[QUO_BITS-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_BITS'(QUO_BITS - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign done_o = done_q;
  assign quot_o = (quo_q[QUO_BITS-1:DIST_BITS] != '0) ? dist_t'(DIST_MAX)
                                                       : quo_q[DIST_BITS-1:0];
endmodule

// ----- sv/grc_mul.sv -----
// Shared signed multiplier with a registered product.
module grc_mul (
  input  logic           clk_i,
  input  grc_pkg::op_t   a_i,
  input  grc_pkg::op_t   b_i,
  output grc_pkg::prod_t p_o
);
  import grc_pkg::*;

  prod_t p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;
endmodule

// ----- sv/grid_ray_caster_top.sv -----
// Grid ray caster top level: map memory, sequencer and the DDA walk.
//
//  channel  | ports                                               | flow
//  request  | start_i, busy_o, command_i, cell_*, origin_*, dir_* | taken when start_i & !busy_o
//           | fish_cos_i                                          |
//  result   | done_o, hit_*, *_distance_o, tex_u_o                | one-cycle strobe on done_o
//
// After reset all 4096 map cells are swept to empty, one cell a cycle, with busy_o high.
// A write leaves busy_o low. A cast keeps busy_o high through two runs of the shared
// reciprocal divider, the two border products, a read and a check per map cell (one
// per grid step plus the start cell), and the intersection, the fisheye product
// and the texture coordinate.
// Results cannot be stalled; done_o is high for one cycle per cast, in the first cycle
// with busy_o low again.
module grid_ray_caster_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        command_i,
  input  logic [5:0]  cell_x_i,
  input  logic [5:0]  cell_y_i,
  input  logic        cell_solid_i,
  input  logic [7:0]  cell_code_i,
  input  logic [15:0] origin_x_i,
  input  logic [15:0] origin_y_i,
  input  logic signed [15:0] dir_x_i,
  input  logic signed [15:0] dir_y_i,
  input  logic [14:0] fish_cos_i,
  output logic        done_o,
  output logic [5:0]  hit_x_o,
  output logic [5:0]  hit_y_o,
  output logic [7:0]  hit_code_o,
  output logic [16:0] raw_distance_o,
  output logic [16:0] view_distance_o,
  output logic [9:0]  tex_u_o,
  output logic        hit_solid_o
);
  import grc_pkg::*;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DIVX  = 4'd2;
  localparam logic [3:0] S_DIVY  = 4'd3;
  localparam logic [3:0] S_LENX  = 4'd4;
  localparam logic [3:0] S_LENY  = 4'd5;
  localparam logic [3:0] S_RD    = 4'd6;
  localparam logic [3:0] S_CK    = 4'd7;
  localparam logic [3:0] S_MIX   = 4'd8;
  localparam logic [3:0] S_MIY   = 4'd9;
  localparam logic [3:0] S_MVW   = 4'd10;
  localparam logic [3:0] S_OFF   = 4'd11;
  localparam logic [3:0] S_TEX   = 4'd12;

  logic [3:0] state_q, state_d;
  logic [ADDR_BITS-1:0] clr_q, clr_d;
  logic done_q, done_d;
  logic leny_take_q;

  logic [15:0] ox_q, oy_q, ox_d, oy_d;
  logic signed [15:0] dx_q, dy_q, dx_d, dy_d;
  logic [14:0] fish_q, fish_d;
  dist_t delx_q, dely_q, lenx_q, leny_q, walk_q;
  dist_t delx_d, dely_d, lenx_d, leny_d, walk_d;
  logic signed [7:0] cx_q, cy_q, cx_d, cy_d;
  logic [CODE_BITS-1:0] code_q, code_d;
  logic solid_q, solid_d;
  logic signed [POS_BITS-1:0] ix_q, iy_q, ix_d, iy_d, offx_q, offy_q, offx_d, offy_d;
  dist_t view_q, view_d;

  logic [5:0] hx_q, hy_q, hx_d, hy_d;
  logic [7:0] hc_q, hc_d;
  dist_t raw_q, raw_d, vo_q, vo_d;
  logic [9:0] tu_q, tu_d;
  logic hs_q, hs_d;

  // Map memory
  logic ram_we;
  logic [ADDR_BITS-1:0] ram_waddr, ram_raddr;
  logic [ENTRY_BITS-1:0] ram_wdata, ram_rdata;

  // Shared units
  logic div_start, div_done;
  logic [15:0] div_arg;
  dist_t div_quot;
  op_t mul_a, mul_b;
  prod_t mul_p;

  logic in_map;
  logic [15:0] abs_dy;
  dist_t lenx_p, leny_p, sumx, sumy;
  logic [17:0] addx, addy;
  logic sample_y;
  logic signed [POS_BITS-1:0] diff;

  grc_ram #(.WIDTH(ENTRY_BITS), .DEPTH(CELL_COUNT)) u_map (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  grc_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .divisor_i(div_arg),
    .done_o   (div_done),
    .quot_o   (div_quot)
  );

  grc_mul u_mul (
    .clk_i(clk_i),
    .a_i  (mul_a),
    .b_i  (mul_b),
    .p_o  (mul_p)
  );

  assign busy_o    = state_q != S_IDLE;
  assign ram_raddr = {cy_q[CELL_BITS-1:0], cx_q[CELL_BITS-1:0]};
  assign in_map    = (cx_q >= 0) && (cx_q < 8'(MAP_SIDE)) && (cy_q >= 0)
                     && (cy_q < 8'(MAP_SIDE));
  assign abs_dy    = dy_q[15] ? 16'(-dy_q) : 16'(dy_q);

  // Step sums saturate at the distance ceiling.
  assign addx = {1'b0, lenx_q} + {1'b0, delx_q};
  assign addy = {1'b0, leny_q} + {1'b0, dely_q};
  assign sumx = addx[17] ? dist_t'(DIST_MAX) : addx[16:0];
  assign sumy = addy[17] ? dist_t'(DIST_MAX) : addy[16:0];

  // First border distance: (fraction to border * delta) >> FRAC_BITS, saturated.
  assign lenx_p = (mul_p[PROD_BITS-1:DIST_BITS+FRAC_BITS] != '0) ? dist_t'(DIST_MAX)
                  : mul_p[DIST_BITS+FRAC_BITS-1:FRAC_BITS];
  assign leny_p = lenx_p;

  always_comb begin
    sample_y = ((offx_q == 0) && (offy_q == 0))
            || ((offx_q > 0) && (offy_q >= -offx_q) && (offy_q < offx_q))
            || ((offx_q < 0) && (offy_q > offx_q) && (offy_q <= -offx_q));
    diff = sample_y ? iy_q - (POS_BITS'(cy_q) <<< (FRAC_BITS + 14))
                    : ix_q - (POS_BITS'(cx_q) <<< (FRAC_BITS + 14));
  end

  always_comb begin
    state_d = state_q;
    clr_d = clr_q;
    done_d = 1'b0;
    ox_d = ox_q; oy_d = oy_q; dx_d = dx_q; dy_d = dy_q; fish_d = fish_q;
    delx_d = delx_q; dely_d = dely_q; lenx_d = lenx_q; leny_d = leny_q;
    walk_d = walk_q; cx_d = cx_q; cy_d = cy_q; code_d = code_q; solid_d = solid_q;
    ix_d = ix_q; iy_d = iy_q; offx_d = offx_q; offy_d = offy_q; view_d = view_q;
    hx_d = hx_q; hy_d = hy_q; hc_d = hc_q; raw_d = raw_q; vo_d = vo_q;
    tu_d = tu_q; hs_d = hs_q;
    ram_we = 1'b0;
    ram_waddr = {cell_y_i, cell_x_i};
    ram_wdata = {cell_solid_i, cell_code_i};
    div_start = 1'b0;
    div_arg = dir_x_i[15] ? 16'(-dir_x_i) : 16'(dir_x_i);
    mul_a = '0;
    mul_b = '0;

    unique case (state_q)
      S_CLEAR: begin
        ram_we = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d = clr_q + 1'b1;
        if (clr_q == ADDR_BITS'(CELL_COUNT - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          if (!command_i) begin
            ram_we = 1'b1;
          end else begin
            div_start = 1'b1;
            ox_d = origin_x_i; oy_d = origin_y_i;
            dx_d = dir_x_i; dy_d = dir_y_i; fish_d = fish_cos_i;
            cx_d = 8'(origin_x_i[15:FRAC_BITS]);
            cy_d = 8'(origin_y_i[15:FRAC_BITS]);
            walk_d = '0;
            state_d = S_DIVX;
          end
        end
      end
      S_DIVX: begin
        div_arg = abs_dy;
        if (div_done) begin
          delx_d = div_quot;
          div_start = 1'b1;
          state_d = S_DIVY;
        end
      end
      S_DIVY: begin
        div_arg = abs_dy;
        if (div_done) begin
          dely_d = div_quot;
          state_d = S_LENX;
        end
      end
      S_LENX: begin
        mul_a = op_t'(dx_q[15] ? {1'b0, ox_q[FRAC_BITS-1:0]}
                               : 11'((1 << FRAC_BITS) - {1'b0, ox_q[FRAC_BITS-1:0]}));
        mul_b = op_t'(delx_q);
        state_d = S_LENY;
      end
      S_LENY: begin
        lenx_d = lenx_p;
        mul_a = op_t'(dy_q[15] ? {1'b0, oy_q[FRAC_BITS-1:0]}
                               : 11'((1 << FRAC_BITS) - {1'b0, oy_q[FRAC_BITS-1:0]}));
        mul_b = op_t'(dely_q);
        state_d = S_RD;
      end
      S_RD: begin
        // The first pass lands here right after the second border product.
        if (leny_take_q) begin
          leny_d = leny_p;
        end
        state_d = S_CK;
      end
      S_CK: begin
        if (!in_map || ram_rdata[ENTRY_BITS-1] || walk_q >= dist_t'(LIMIT)) begin
          code_d  = in_map ? ram_rdata[CODE_BITS-1:0] : '0;
          solid_d = in_map ? ram_rdata[ENTRY_BITS-1] : 1'b1;
          state_d = S_MIX;
        end else begin
          if (lenx_q < leny_q) begin
            cx_d = dx_q[15] ? cx_q - 8'sd1 : cx_q + 8'sd1;
            walk_d = lenx_q;
            lenx_d = sumx;
          end else begin
            cy_d = dy_q[15] ? cy_q - 8'sd1 : cy_q + 8'sd1;
            walk_d = leny_q;
            leny_d = sumy;
          end
          state_d = S_RD;
        end
      end
      S_MIX: begin
        mul_a = op_t'(dx_q);
        mul_b = op_t'(walk_q);
        state_d = S_MIY;
      end
      S_MIY: begin
        ix_d = (POS_BITS'(ox_q) <<< 14) + POS_BITS'(mul_p);
        mul_a = op_t'(dy_q);
        mul_b = op_t'(walk_q);
        state_d = S_MVW;
      end
      S_MVW: begin
        iy_d = (POS_BITS'(oy_q) <<< 14) + POS_BITS'(mul_p);
        mul_a = op_t'(walk_q);
        mul_b = op_t'(fish_q);
        state_d = S_OFF;
      end
      S_OFF: begin
        view_d = (mul_p[PROD_BITS-1:DIST_BITS+14] != '0) ? dist_t'(DIST_MAX)
                 : mul_p[DIST_BITS+13:14];
        offx_d = ix_q - (((POS_BITS'(cx_q) <<< 1) + 1) <<< (FRAC_BITS + 13));
        offy_d = iy_q - (((POS_BITS'(cy_q) <<< 1) + 1) <<< (FRAC_BITS + 13));
        state_d = S_TEX;
      end
      S_TEX: begin
        hx_d = (cx_q < 0) ? 6'd0 : (cx_q > 8'sd63) ? 6'd63 : cx_q[5:0];
        hy_d = (cy_q < 0) ? 6'd0 : (cy_q > 8'sd63) ? 6'd63 : cy_q[5:0];
        hc_d = code_q;
        hs_d = solid_q;
        raw_d = walk_q;
        vo_d = view_q;
        if (diff <= 0) begin
          tu_d = '0;
        end else if (diff[POS_BITS-1:FRAC_BITS+14] != '0) begin
          tu_d = 10'd1023;
        end else begin
          tu_d = diff[FRAC_BITS+13:FRAC_BITS+4];
        end
        done_d = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
    end
  end

  // Marks the read cycle on which the second border product is ready.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leny_take_q <= 1'b0;
    end else begin
      leny_take_q <= state_q == S_LENY;
    end
  end

  always_ff @(posedge clk_i) begin
    ox_q <= ox_d; oy_q <= oy_d; dx_q <= dx_d; dy_q <= dy_d; fish_q <= fish_d;
    delx_q <= delx_d; dely_q <= dely_d; lenx_q <= lenx_d; leny_q <= leny_d;
    walk_q <= walk_d; cx_q <= cx_d; cy_q <= cy_d; code_q <= code_d; solid_q <= solid_d;
    ix_q <= ix_d; iy_q <= iy_d; offx_q <= offx_d; offy_q <= offy_d; view_q <= view_d;
    hx_q <= hx_d; hy_q <= hy_d; hc_q <= hc_d; raw_q <= raw_d; vo_q <= vo_d;
    tu_q <= tu_d; hs_q <= hs_d;
  end

  assign done_o          = done_q;
  assign hit_x_o         = hx_q;
  assign hit_y_o         = hy_q;
  assign hit_code_o      = hc_q;
  assign raw_distance_o  = raw_q;
  assign view_distance_o = vo_q;
  assign tex_u_o         = tu_q;
  assign hit_solid_o     = hs_q;

`ifndef SYNTHESIS
  a_clear_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |-> busy_o) else $error("map sweep not busy");
  a_depth_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !hit_solid_o |-> raw_distance_o >= 17'(LIMIT))
    else $error("walk ended empty before the depth limit");
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");
  a_off_map_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CK && !in_map |=> state_q == S_MIX)
    else $error("walk continued outside the map");
`endif
endmodule

// ----- verif/grid_ray_caster_top_tb.sv -----
// Self-checking testbench for the grid ray caster: map writes and DDA ray casts.
module grid_ray_caster_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import grc_pkg::*;

  typedef enum logic {CMD_WRITE = 1'b0, CMD_CAST = 1'b1} cmd_e;

  typedef struct packed {
    logic [5:0]  hit_x;
    logic [5:0]  hit_y;
    logic [7:0]  hit_code;
    logic [16:0] raw_distance;
    logic [16:0] view_distance;
    logic [9:0]  tex_u;
    logic        hit_solid;
  } hit_t;

  class hit_scoreboard;
    logic [ENTRY_BITS-1:0] map_copy[CELL_COUNT];
    hit_t pending_hits[$];
    int mismatches;
    int casts_seen;
    int solid_hits;
    int depth_stops;

    function new();
      foreach (map_copy[i]) map_copy[i] = '0;
      mismatches = 0;
      casts_seen = 0;
      solid_hits = 0;
      depth_stops = 0;
    endfunction

    function longint sat_dist(longint v);
      return (v > longint'(DIST_MAX)) ? longint'(DIST_MAX) : v;
    endfunction

    function longint step_length(longint d);
      longint a;
      a = (d < 0) ? -d : d;
      if (a == 0) return longint'(DIST_MAX);
      return sat_dist((longint'(1) << (14 + FRAC_BITS)) / a);
    endfunction

    function bit on_map(longint x, longint y);
      return x >= 0 && y >= 0 && x < MAP_SIDE && y < MAP_SIDE;
    endfunction

    function logic [ENTRY_BITS-1:0] cell_at(longint x, longint y);
      if (!on_map(x, y)) return {1'b1, {CODE_BITS{1'b0}}};
      return map_copy[y * MAP_SIDE + x];
    endfunction

    function longint clamp_cell(longint c);
      if (c < 0) return 0;
      if (c > MAP_SIDE - 1) return MAP_SIDE - 1;
      return c;
    endfunction

    function hit_t cast_ray(longint ox, longint oy, longint dx, longint dy, longint fish);
      hit_t r;
      longint one, cx, cy, fx, fy, delx, dely, sx, sy, lenx, leny, walk;
      longint ix, iy, half, offx, offy, diff, u;
      logic [ENTRY_BITS-1:0] stop_entry;
      bit sample_y;
      one = longint'(1) << FRAC_BITS;
      cx = ox >> FRAC_BITS;
      cy = oy >> FRAC_BITS;
      fx = ox & (one - 1);
      fy = oy & (one - 1);
      delx = step_length(dx);
      dely = step_length(dy);
      sx = (dx < 0) ? -1 : 1;
      sy = (dy < 0) ? -1 : 1;
      lenx = sat_dist((((dx < 0) ? fx : one - fx) * delx) >> FRAC_BITS);
      leny = sat_dist((((dy < 0) ? fy : one - fy) * dely) >> FRAC_BITS);
      walk = 0;
      stop_entry = cell_at(cx, cy);
      while (!stop_entry[CODE_BITS] && walk < longint'(LIMIT)) begin
        if (lenx < leny) begin
          cx += sx;
          walk = lenx;
          lenx = sat_dist(lenx + delx);
        end else begin
          cy += sy;
          walk = leny;
          leny = sat_dist(leny + dely);
        end
        stop_entry = cell_at(cx, cy);
      end
      ix = (ox << 14) + dx * walk;
      iy = (oy << 14) + dy * walk;
      half = longint'(1) << (FRAC_BITS + 13);
      offx = ix - (2 * cx + 1) * half;
      offy = iy - (2 * cy + 1) * half;
      // East and west faces, and the exact centre, take the texture from y.
      sample_y = (offx == 0 && offy == 0) ||
                 (offx > 0 && offy >= -offx && offy < offx) ||
                 (offx < 0 && offy > offx && offy <= -offx);
      diff = sample_y ? iy - cy * 2 * half : ix - cx * 2 * half;
      if (diff <= 0) u = 0;
      else begin
        u = diff >> (FRAC_BITS + 4);
        if (u > 1023) u = 1023;
      end
      r.hit_x = 6'(clamp_cell(cx));
      r.hit_y = 6'(clamp_cell(cy));
      r.hit_code = on_map(cx, cy) ? stop_entry[CODE_BITS-1:0] : '0;
      r.raw_distance = 17'(walk);
      r.view_distance = 17'(sat_dist((walk * fish) >> 14));
      r.tex_u = 10'(u);
      r.hit_solid = stop_entry[CODE_BITS];
      return r;
    endfunction

    function void note_request(cmd_e cmd, logic [5:0] cx, logic [5:0] cy, logic solid,
                               logic [7:0] code, logic [15:0] ox, logic [15:0] oy,
                               logic signed [15:0] dx, logic signed [15:0] dy,
                               logic [14:0] fish);
      hit_t h;
      if (cmd == CMD_WRITE) begin
        if (cx < MAP_SIDE && cy < MAP_SIDE)
          map_copy[cy * MAP_SIDE + cx] = {solid, code[CODE_BITS-1:0]};
      end else begin
        h = cast_ray(longint'(ox), longint'(oy), longint'(dx), longint'(dy), longint'(fish));
        pending_hits = {pending_hits, h};
        casts_seen++;
        if (h.hit_solid) solid_hits++;
        else depth_stops++;
      end
    endfunction

    function void check_result(hit_t got);
      hit_t want;
      if (pending_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Result with no cast outstanding: %p", got);
        return;
      end
      want = pending_hits.pop_front();
      if (got != want) begin
        mismatches++;
        if (mismatches <= 10) $display("Cast mismatch:\n  expected %p\n  actual   %p", want, got);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic command_i = 1'b0;
  logic [5:0] cell_x_i = '0;
  logic [5:0] cell_y_i = '0;
  logic cell_solid_i = 1'b0;
  logic [7:0] cell_code_i = '0;
  logic [15:0] origin_x_i = '0;
  logic [15:0] origin_y_i = '0;
  logic signed [15:0] dir_x_i = '0;
  logic signed [15:0] dir_y_i = '0;
  logic [14:0] fish_cos_i = '0;
  logic busy_o, done_o, hit_solid_o;
  logic [5:0] hit_x_o, hit_y_o;
  logic [7:0] hit_code_o;
  logic [16:0] raw_distance_o, view_distance_o;
  logic [9:0] tex_u_o;

  hit_scoreboard sb = new();
  int idle_cycles = 0;

  grid_ray_caster_top uut (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    hit_t got;
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        sb.note_request(cmd_e'(command_i), cell_x_i, cell_y_i, cell_solid_i, cell_code_i,
                        origin_x_i, origin_y_i, dir_x_i, dir_y_i, fish_cos_i);
      end
      if (done_o) begin
        got.hit_x = hit_x_o;
        got.hit_y = hit_y_o;
        got.hit_code = hit_code_o;
        got.raw_distance = raw_distance_o;
        got.view_distance = view_distance_o;
        got.tex_u = tex_u_o;
        got.hit_solid = hit_solid_o;
        sb.check_result(got);
      end
      if ((start_i && !busy_o) || done_o) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles > 20000) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Holds start until the request is taken; the caller decides what follows.
  task automatic issue(cmd_e cmd, logic [5:0] cx, logic [5:0] cy, logic solid,
                       logic [7:0] code, logic [15:0] ox, logic [15:0] oy,
                       logic [15:0] dx, logic [15:0] dy, logic [14:0] fish);
    start_i <= 1'b1;
    command_i <= cmd;
    cell_x_i <= cx;
    cell_y_i <= cy;
    cell_solid_i <= solid;
    cell_code_i <= code;
    origin_x_i <= ox;
    origin_y_i <= oy;
    dir_x_i <= dx;
    dir_y_i <= dy;
    fish_cos_i <= fish;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic write_cell(logic [5:0] cx, logic [5:0] cy, logic solid, logic [7:0] code);
    issue(CMD_WRITE, cx, cy, solid, code, 16'($urandom), 16'($urandom), 16'($urandom),
          16'($urandom), 15'($urandom));
  endtask

  task automatic cast(logic [15:0] ox, logic [15:0] oy, logic [15:0] dx, logic [15:0] dy,
                      logic [14:0] fish);
    issue(CMD_CAST, 6'($urandom), 6'($urandom), 1'($urandom), 8'($urandom),
          ox, oy, dx, dy, fish);
  endtask

  task automatic random_gap();
    int n, pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) n = 0;
    else if (pick < 90) n = $urandom_range(1, 4);
    else n = $urandom_range(10, 150);
    if (n > 0) begin
      start_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  function automatic logic [15:0] random_dir();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) return '0;
    if (pick < 14) return 16'($urandom);
    if (pick < 20) return ($urandom_range(0, 1) != 0) ? 16'sd16384 : -16'sd16384;
    return 16'($urandom_range(0, 32768) - 16384);
  endfunction

  function automatic logic [15:0] random_origin();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return {6'($urandom), 10'd512};
    if (pick == 1) return {6'($urandom), 10'd0};
    return 16'($urandom);
  endfunction

  initial begin
    int burst_phase;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty map, then written walls; zero and extreme directions, corners and centres.
    cast(16'h8200, 16'h8200, 16'sd16384, 16'sd0, 15'd16384);
    cast(16'h8200, 16'h8200, -16'sd16384, 16'sd0, 15'd16384);
    cast(16'h8200, 16'h8200, 16'sd0, 16'sd0, 15'd32767);
    cast(16'h0000, 16'h0000, -16'sd16384, -16'sd16384, 15'd0);
    cast(16'hFFFF, 16'hFFFF, 16'sd11585, 16'sd11585, 15'd11585);
    cast(16'h8200, 16'h8200, 16'h7FFF, 16'h8000, 15'd16384);
    write_cell(6'd40, 6'd32, 1'b1, 8'hFF);
    write_cell(6'd0, 6'd0, 1'b1, 8'h00);
    write_cell(6'd63, 6'd63, 1'b1, 8'hA5);
    write_cell(6'd33, 6'd32, 1'b0, 8'h5A);
    cast(16'h8200, 16'h8200, 16'sd16384, 16'sd0, 15'd16384);
    cast(16'h8200, 16'h8200, 16'sd16384, 16'sd1, 15'd32767);
    cast(16'h0200, 16'h0200, 16'sd3, -16'sd2, 15'd8192);
    cast(16'hFE00, 16'hFE00, 16'sd5000, 16'sd5000, 15'd16384);
    cast(16'h0000, 16'h0000, 16'sd100, 16'sd100, 15'd16384);
    cast(16'h8400, 16'h8200, -16'sd16384, 16'sd0, 15'd1);
    write_cell(6'd40, 6'd32, 1'b0, 8'h11);
    cast(16'h8200, 16'h8200, 16'sd1, 16'sd0, 15'd16384);
    cast(16'h8200, 16'h8000, 16'sd11585, 16'sd11585, 15'd16384);
    start_i <= 1'b0;

    // Random: map edits interleaved with casts; bursts of walls keep hits varied.
    for (int i = 0; i < 1880; i++) begin
      burst_phase = i % 200;
      if (i == 940) begin
        start_i <= 1'b0;
        while (sb.pending_hits.size() != 0) @(posedge clk_i);
      end
      if (burst_phase < 30 || $urandom_range(0, 99) < 35)
        write_cell(6'($urandom), 6'($urandom), $urandom_range(0, 99) < 40, 8'($urandom));
      else
        cast(random_origin(), random_origin(), random_dir(), random_dir(),
             ($urandom_range(0, 19) == 0) ? 15'($urandom) : 15'($urandom_range(0, 16384)));
      if (burst_phase >= 100 && burst_phase < 130) begin
        // A stretch with no pauses between requests.
      end else begin
        random_gap();
      end
    end
    start_i <= 1'b0;

    while (sb.pending_hits.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);

    $display("Cast %0d rays: %0d stopped on a solid cell, %0d at the depth limit.",
             sb.casts_seen, sb.solid_hits, sb.depth_stops);
    $display("Mismatches: %0d, casts still outstanding: %0d.",
             sb.mismatches, sb.pending_hits.size());
    if (sb.mismatches == 0 && sb.pending_hits.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
